// ===== sv/ftvd_pkg.sv =====
`default_nettype none

package ftvd_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int IDX_OUT_W       = 10;
    localparam int FACE_SIZE_W     = 16;
    localparam int WORD_W          = 32;
    localparam int KEY_W           = 64;
    localparam int KEY_WORDS       = 4;

    localparam logic [FACE_SIZE_W-1:0] SHORT_FACE_LIMIT = FACE_SIZE_W'(2);

    // Largest magnitude that is not a NaN (the infinity pattern).
    localparam logic [WORD_W-2:0] INF_MAG = 31'h7F80_0000;

    // Four packed 64-bit keys: pos xy, pos z / nor x, nor yz, tex uv.
    typedef logic [KEY_WORDS-1:0][KEY_W-1:0] key_t;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_FULL     = 2'd2
    } status_t;

    // Float equality on raw bit patterns: +0 == -0, NaN never matches.
    function automatic logic word_equal(input logic [WORD_W-1:0] a,
                                        input logic [WORD_W-1:0] b);
        logic [WORD_W-2:0] ma;
        logic [WORD_W-2:0] mb;
        logic              eq;
        ma = a[WORD_W-2:0];
        mb = b[WORD_W-2:0];
        if ((ma > INF_MAG) || (mb > INF_MAG))
        begin
            eq = 1'b0;
        end
        else if ((ma == '0) && (mb == '0))
        begin
            eq = 1'b1;
        end
        else
        begin
            eq = (a == b);
        end
        return eq;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ftvd_ram.sv =====
`default_nettype none

module ftvd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/ftvd_key_cmp.sv =====
`default_nettype none

module ftvd_key_cmp
    import ftvd_pkg::*;
(
    input  wire key_t stored,
    input  wire key_t probe,
    output logic      match
);

    logic [2*KEY_WORDS-1:0] lane_eq;

    // Eight independent float compares, ANDed.
    always_comb
    begin
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            lane_eq[2*i]   = word_equal(stored[i][WORD_W-1:0], probe[i][WORD_W-1:0]);
            lane_eq[2*i+1] = word_equal(stored[i][KEY_W-1:WORD_W],
                                        probe[i][KEY_W-1:WORD_W]);
        end
        match = &lane_eq;
    end

endmodule

`default_nettype wire

// ===== sv/fan_triangulate_vertex_dedup_unit.sv =====
`default_nettype none

// Polygon fan triangulation with vertex deduplication. Each input transaction
// carries one face vertex (eight raw IEEE single patterns plus group_start,
// face_start and face_size) and produces exactly one result transaction with
// status, the dense vertex index, an is_new flag and, from the third vertex
// of a face on, the fan triangle (first, previous, current). Vertices are
// matched by float equality of all eight words (+0 equals -0, NaN never
// matches) against a table of up to TABLE_DEPTH distinct vertices held in four
// 64-bit wide RAMs. group_start empties the table by zeroing the fill count;
// no clearing pass is needed, so the block is ready right after reset. The
// lookup is a linear scan: the RAMs are read one entry per cycle and a single
// shared compare unit checks the registered read data against the probe key.
// The block takes one vertex at a time and holds vtx_stall high while it
// works. With N distinct vertices stored, a vertex found at entry i occupies
// the block until entry i is compared, a new one until all N are; short-face
// and broken-face vertices skip the scan. The scan length, i.e. the single RAM
// read port feeding the compare unit, sets this occupancy. A finished result
// sits in an output register, so the next vertex is accepted while res_valid
// waits on res_stall. Output indices are the low 10 bits of the table index.
module fan_triangulate_vertex_dedup_unit
    import ftvd_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   vtx_valid,
    output logic                        vtx_stall,
    input  wire logic                   group_start,
    input  wire logic                   face_start,
    input  wire logic [FACE_SIZE_W-1:0] face_size,
    input  wire logic [WORD_W-1:0]      pos_x,
    input  wire logic [WORD_W-1:0]      pos_y,
    input  wire logic [WORD_W-1:0]      pos_z,
    input  wire logic [WORD_W-1:0]      nor_x,
    input  wire logic [WORD_W-1:0]      nor_y,
    input  wire logic [WORD_W-1:0]      nor_z,
    input  wire logic [WORD_W-1:0]      tex_u,
    input  wire logic [WORD_W-1:0]      tex_v,

    output logic                        res_valid,
    input  wire logic                   res_stall,
    output logic [1:0]                  status,
    output logic [IDX_OUT_W-1:0]        vertex_index,
    output logic                        is_new,
    output logic                        tri_valid,
    output logic [IDX_OUT_W-1:0]        tri_a,
    output logic [IDX_OUT_W-1:0]        tri_b,
    output logic [IDX_OUT_W-1:0]        tri_c
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        FACE_FIRST,
        FACE_SECOND,
        FACE_FAN
    } face_pos_t;

    // Control state
    state_t          state_reg,     state_next;
    logic [CW-1:0]   count_reg,     count_next;
    logic [AW-1:0]   first_reg,     first_next;
    logic [AW-1:0]   prev_reg,      prev_next;
    face_pos_t       face_pos_reg,  face_pos_next;
    logic            broken_reg,    broken_next;
    logic [CW-1:0]   issue_ptr_reg, issue_ptr_next;
    logic            cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]   cmp_ptr_reg,   cmp_ptr_next;
    logic            res_valid_reg, res_valid_next;

    // Payload
    key_t                 probe_reg,       probe_next;
    status_t              pend_status_reg, pend_status_next;
    logic [IDX_OUT_W-1:0] pend_index_reg,  pend_index_next;
    logic                 pend_new_reg,    pend_new_next;
    logic                 pend_tri_reg,    pend_tri_next;
    logic [IDX_OUT_W-1:0] pend_a_reg,      pend_a_next;
    logic [IDX_OUT_W-1:0] pend_b_reg,      pend_b_next;
    logic [IDX_OUT_W-1:0] pend_c_reg,      pend_c_next;
    logic [1:0]           status_reg,      status_next;
    logic [IDX_OUT_W-1:0] index_reg,       index_next;
    logic                 new_reg,         new_next;
    logic                 tri_reg,         tri_next;
    logic [IDX_OUT_W-1:0] a_reg,           a_next;
    logic [IDX_OUT_W-1:0] b_reg,           b_next;
    logic [IDX_OUT_W-1:0] c_reg,           c_next;

    logic          ram_we;
    key_t          stored_key;
    logic          key_match;
    logic          scan_last;
    logic          resolve;
    logic [AW-1:0] resolve_idx;
    logic          resolve_new;

    // ------------------------------------------------------------------
    // Key table: four RAMs, written at the fill count, read at the scan ptr
    // ------------------------------------------------------------------
    for (genvar g = 0; g < KEY_WORDS; g++)
    begin : g_key_ram
        ftvd_ram #(
            .WIDTH (KEY_W),
            .DEPTH (TABLE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (count_reg[AW-1:0]),
            .wdata (probe_reg[g]),
            .raddr (issue_ptr_reg[AW-1:0]),
            .rdata (stored_key[g])
        );
    end

    // Shared compare unit: one stored entry per cycle against the probe
    ftvd_key_cmp u_cmp (
        .stored (stored_key),
        .probe  (probe_reg),
        .match  (key_match)
    );

    assign scan_last = ((CW'(cmp_ptr_reg) + CW'(1)) == count_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        first_next       = first_reg;
        prev_next        = prev_reg;
        face_pos_next    = face_pos_reg;
        broken_next      = broken_reg;
        issue_ptr_next   = issue_ptr_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_ptr_next     = cmp_ptr_reg;
        res_valid_next   = res_valid_reg && res_stall;

        probe_next       = probe_reg;
        pend_status_next = pend_status_reg;
        pend_index_next  = pend_index_reg;
        pend_new_next    = pend_new_reg;
        pend_tri_next    = pend_tri_reg;
        pend_a_next      = pend_a_reg;
        pend_b_next      = pend_b_reg;
        pend_c_next      = pend_c_reg;
        status_next      = status_reg;
        index_next       = index_reg;
        new_next         = new_reg;
        tri_next         = tri_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        c_next           = c_reg;

        ram_we      = 1'b0;
        resolve     = 1'b0;
        resolve_idx = '0;
        resolve_new = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (vtx_valid)
                begin
                    // Group start empties the table and restarts face tracking
                    if (group_start)
                    begin
                        count_next    = '0;
                        face_pos_next = FACE_FIRST;
                        broken_next   = 1'b0;
                    end
                    if (face_start)
                    begin
                        face_pos_next = FACE_FIRST;
                        broken_next   = 1'b0;
                    end
                    probe_next       = {tex_v, tex_u, nor_z, nor_y, nor_x, pos_z,
                                        pos_y, pos_x};
                    issue_ptr_next   = '0;
                    cmp_valid_next   = 1'b0;
                    pend_index_next  = '0;
                    pend_new_next    = 1'b0;
                    pend_tri_next    = 1'b0;
                    pend_a_next      = '0;
                    pend_b_next      = '0;
                    pend_c_next      = '0;
                    if (face_size <= SHORT_FACE_LIMIT)
                    begin
                        // Short face: result only, tracking beyond the starts untouched
                        pend_status_next = STATUS_SHORT;
                        state_next       = S_EMIT;
                    end
                    else if (broken_next)
                    begin
                        pend_status_next = STATUS_FULL;
                        state_next       = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                cmp_valid_next = 1'b0;
                cmp_ptr_next   = issue_ptr_reg[AW-1:0];
                if (cmp_valid_reg && key_match)
                begin
                    resolve     = 1'b1;
                    resolve_idx = cmp_ptr_reg;
                    state_next  = S_EMIT;
                end
                else if ((cmp_valid_reg && scan_last) ||
                         (!cmp_valid_reg && (issue_ptr_reg == count_reg)))
                begin
                    // Not found anywhere: append, or flag the full table
                    if (count_reg == DEPTH_C)
                    begin
                        pend_status_next = STATUS_FULL;
                        broken_next      = 1'b1;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        count_next  = count_reg + CW'(1);
                        resolve     = 1'b1;
                        resolve_idx = count_reg[AW-1:0];
                        resolve_new = 1'b1;
                    end
                    state_next = S_EMIT;
                end
                else if (issue_ptr_reg != count_reg)
                begin
                    issue_ptr_next = issue_ptr_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                end
            end

            S_EMIT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    status_next    = pend_status_reg;
                    index_next     = pend_index_reg;
                    new_next       = pend_new_reg;
                    tri_next       = pend_tri_reg;
                    a_next         = pend_a_reg;
                    b_next         = pend_b_reg;
                    c_next         = pend_c_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Accepted vertex: index result and fan bookkeeping
        if (resolve)
        begin
            pend_status_next = STATUS_ACCEPTED;
            pend_index_next  = IDX_OUT_W'(resolve_idx);
            pend_new_next    = resolve_new;
            case (face_pos_reg)
                FACE_FIRST:
                begin
                    first_next    = resolve_idx;
                    face_pos_next = FACE_SECOND;
                end
                FACE_SECOND:
                begin
                    face_pos_next = FACE_FAN;
                end
                default:
                begin
                    pend_tri_next = 1'b1;
                    pend_a_next   = IDX_OUT_W'(first_reg);
                    pend_b_next   = IDX_OUT_W'(prev_reg);
                    pend_c_next   = IDX_OUT_W'(resolve_idx);
                end
            endcase
            prev_next = resolve_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            first_reg       <= '0;
            prev_reg        <= '0;
            face_pos_reg    <= FACE_FIRST;
            broken_reg      <= 1'b0;
            issue_ptr_reg   <= '0;
            cmp_valid_reg   <= 1'b0;
            cmp_ptr_reg     <= '0;
            res_valid_reg   <= 1'b0;
            probe_reg       <= '0;
            pend_status_reg <= STATUS_ACCEPTED;
            pend_index_reg  <= '0;
            pend_new_reg    <= 1'b0;
            pend_tri_reg    <= 1'b0;
            pend_a_reg      <= '0;
            pend_b_reg      <= '0;
            pend_c_reg      <= '0;
            status_reg      <= '0;
            index_reg       <= '0;
            new_reg         <= 1'b0;
            tri_reg         <= 1'b0;
            a_reg           <= '0;
            b_reg           <= '0;
            c_reg           <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            first_reg       <= first_next;
            prev_reg        <= prev_next;
            face_pos_reg    <= face_pos_next;
            broken_reg      <= broken_next;
            issue_ptr_reg   <= issue_ptr_next;
            cmp_valid_reg   <= cmp_valid_next;
            cmp_ptr_reg     <= cmp_ptr_next;
            res_valid_reg   <= res_valid_next;
            probe_reg       <= probe_next;
            pend_status_reg <= pend_status_next;
            pend_index_reg  <= pend_index_next;
            pend_new_reg    <= pend_new_next;
            pend_tri_reg    <= pend_tri_next;
            pend_a_reg      <= pend_a_next;
            pend_b_reg      <= pend_b_next;
            pend_c_reg      <= pend_c_next;
            status_reg      <= status_next;
            index_reg       <= index_next;
            new_reg         <= new_next;
            tri_reg         <= tri_next;
            a_reg           <= a_next;
            b_reg           <= b_next;
            c_reg           <= c_next;
        end
    end

    assign vtx_stall    = (state_reg != S_IDLE);
    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign vertex_index = index_reg;
    assign is_new       = new_reg;
    assign tri_valid    = tri_reg;
    assign tri_a        = a_reg;
    assign tri_b        = b_reg;
    assign tri_c        = c_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("fill count beyond table depth");

    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (count_reg < DEPTH_C) && (state_reg == S_SCAN))
        else $error("table write while full or outside a scan");

    a_tri_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && tri_valid) |-> (status == STATUS_ACCEPTED))
        else $error("triangle on a rejected vertex");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status != STATUS_ACCEPTED)) |->
            ((vertex_index == '0) && !is_new && !tri_valid))
        else $error("rejected vertex carries nonzero fields");

    a_scan_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cmp_valid_reg && key_match) |=> (state_reg == S_EMIT))
        else $error("hit did not end the scan");

endmodule

`default_nettype wire
